>>> design/cfrt_pkg.sv
// shared constants for the rotating acceptance filter tracker
// opcodes, register indexes, field widths; no dependencies
`default_nettype none
package cfrt_pkg;

    // input opcodes
    localparam logic [2:0] OP_SET_WATCH  = 3'd0;
    localparam logic [2:0] OP_LEARN      = 3'd1;
    localparam logic [2:0] OP_BEGIN      = 3'd2;
    localparam logic [2:0] OP_CHECK      = 3'd3;
    localparam logic [2:0] OP_READ_ENTRY = 3'd4;

    // configuration register indexes
    localparam logic CFG_FILTER_SIZE = 1'b0;
    localparam logic CFG_PERIOD_US   = 1'b1;

    // field widths and constants
    localparam int ID_W       = 11;
    localparam int TIME_W     = 52;
    localparam int WATCH_W    = 11;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 120;
    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
    localparam logic [TIME_W-1:0] USEC_PER_SEC = 52'd1000000;
    localparam logic [5:0] FILTER_SIZE_RST = 6'd16;
    localparam logic [31:0] PERIOD_US_RST  = 32'd1000;

    typedef logic [ID_W-1:0] can_id_t;

endpackage
`default_nettype wire

>>> design/can_filter_rotation_tracker.sv
// rotating can acceptance filter tracker, top level
// depends on cfrt_pkg; holds the watch map, learned table and filter slots
`default_nettype none
// One item is taken at a time; s_tready is high only while the sequencer is idle.
// After reset a clearing pass writes the 2048-entry watch map, one entry per cycle,
// so no item is taken until that pass ends (configuration writes are taken).
// Set watch and read entry need no search; a watched learn frame searches the learned
// table one entry at a time, and begin check loads one slot per filter entry. Check
// frame converts the timestamp, compares slots in the final lookup and, when the period
// has expired, visits each slot and, for each logged slot, steps through candidate
// entries and compares each against the slots: all of it runs through the single read
// port of the learned table and one slot comparator. A stalled result holds the block in its last step.
module can_filter_rotation_tracker #(
    parameter int SEQ_ENTRIES  = 128,
    parameter int FILTER_SLOTS = 32
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    // input items: opcode, can_id, watch_enable, time_sec, time_usec, entry_index
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire  [cfrt_pkg::IN_DATA_W-1:0]  s_tdata,
    // results: status, hit, logged_total, missed_total, entry_id, entry_count,
    // learned_total
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [cfrt_pkg::OUT_DATA_W-1:0] m_tdata,
    // configuration writes
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire                           cfg_index,
    input  wire  [31:0]                   cfg_wdata
);
    import cfrt_pkg::*;

    localparam int LCW  = $clog2(SEQ_ENTRIES + 1);
    localparam int SQIW = $clog2(SEQ_ENTRIES);
    localparam int SCW  = $clog2(FILTER_SLOTS + 1);
    localparam int SIW  = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_LRN_ADDR, ST_LRN_CMP, ST_LD_ADDR, ST_LD_WR,
        ST_TM_ADD, ST_TM_CMP, ST_RT_SLOT, ST_RT_STEP, ST_RT_SCAN, ST_LK_SCAN,
        ST_RD_WAIT, ST_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [5:0]  filter_size_reg;
    logic [31:0] period_us_reg;

    // latched item
    logic [2:0]  op_reg;
    can_id_t     id_reg;
    logic [31:0] tsec_reg;
    logic [19:0] tusec_reg;
    logic [6:0]  idx_reg;

    // sequencer state
    logic [WATCH_W-1:0] clr_cnt_reg;
    logic [LCW-1:0]     lc_reg;
    logic [LCW-1:0]     i_reg;
    logic [SCW-1:0]     si_reg;
    logic [SCW-1:0]     j_reg;
    logic [SCW-1:0]     active_reg;
    logic [SQIW-1:0]    ptr_reg;
    logic [SQIW-1:0]    start_reg;
    logic [TIME_W-1:0]  prod_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [TIME_W-1:0]  origin_reg;
    logic               ovalid_reg;
    logic [31:0]        hit_total_reg;
    logic [31:0]        miss_total_reg;
    logic               check_active_reg;
    logic               status_reg;
    logic               hit_reg;
    can_id_t            eid_reg;
    logic [31:0]        ecnt_reg;

    can_id_t slot_ident_reg [FILTER_SLOTS];
    logic    slot_logged_reg [FILTER_SLOTS];

    // memories
    logic    watch_mem [2**WATCH_W];
    logic    watch_q_reg;
    can_id_t seq_id_mem [SEQ_ENTRIES];
    logic [31:0] seq_seen_mem [SEQ_ENTRIES];
    can_id_t seq_id_q_reg;
    logic [31:0] seq_seen_q_reg;

    logic               watch_we, watch_re, watch_wd;
    logic [WATCH_W-1:0] watch_addr;
    logic               seq_re, seq_id_we, seq_seen_we;
    logic [SQIW-1:0]    seq_addr;
    logic [31:0]        seq_seen_wd;

    // input field split
    logic [2:0]  s_opcode;
    can_id_t     s_can_id;
    logic        s_wen;
    assign s_opcode = s_tdata[2:0];
    assign s_can_id = s_tdata[13:3];
    assign s_wen    = s_tdata[14];

    logic s_xfer;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // rotation pointer advance with wrap
    logic [31:0]     ptr_p1;
    logic [SQIW-1:0] ptr_next;
    assign ptr_p1   = 32'(ptr_reg) + 32'd1;
    assign ptr_next = (ptr_p1 >= 32'(lc_reg) || ptr_p1 >= 32'(SEQ_ENTRIES))
                      ? '0 : SQIW'(ptr_p1);

    // slot compare port
    can_id_t slot_j;
    assign slot_j = slot_ident_reg[j_reg[SIW-1:0]];

    // time difference against the effective origin
    logic [TIME_W-1:0] origin_eff;
    logic [TIME_W-1:0] delta;
    assign origin_eff = ovalid_reg ? origin_reg : now_reg;
    assign delta      = now_reg - origin_eff;

    logic bad_start;
    assign bad_start = (filter_size_reg == 6'd0) ||
                       (32'(filter_size_reg) > 32'(FILTER_SLOTS)) ||
                       (32'(filter_size_reg) > 32'(lc_reg));

    logic idx_ok;
    assign idx_ok = 32'(idx_reg) < 32'(lc_reg);

    // memory port control
    always_comb begin
        watch_we    = 1'b0;
        watch_re    = 1'b0;
        watch_wd    = s_wen;
        watch_addr  = s_can_id;
        seq_re      = 1'b0;
        seq_id_we   = 1'b0;
        seq_seen_we = 1'b0;
        seq_addr    = i_reg[SQIW-1:0];
        seq_seen_wd = 32'd1;
        case (state_reg)
            ST_CLEAR: begin
                watch_we   = 1'b1;
                watch_wd   = 1'b0;
                watch_addr = clr_cnt_reg;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    watch_re = 1'b1;
                    watch_we = (s_opcode == OP_SET_WATCH);
                end
            end
            ST_DISPATCH: begin
                if (op_reg == OP_READ_ENTRY && idx_ok) begin
                    seq_re   = 1'b1;
                    seq_addr = SQIW'(idx_reg);
                end
            end
            ST_LRN_ADDR: begin
                if (i_reg < lc_reg) begin
                    seq_re = 1'b1;
                end else if (32'(lc_reg) < 32'(SEQ_ENTRIES)) begin
                    seq_id_we   = 1'b1;
                    seq_seen_we = 1'b1;
                    seq_addr    = lc_reg[SQIW-1:0];
                end
            end
            ST_LRN_CMP: begin
                if (seq_id_q_reg == id_reg) begin
                    seq_seen_we = 1'b1;
                    seq_seen_wd = (seq_seen_q_reg == SAT32) ? SAT32 : seq_seen_q_reg + 32'd1;
                end
            end
            ST_LD_ADDR: begin
                seq_re = (32'(i_reg) < 32'(filter_size_reg));
            end
            ST_RT_STEP: begin
                seq_re   = 1'b1;
                seq_addr = ptr_next;
            end
            default: begin
            end
        endcase
    end

    // watch map memory
    always_ff @(posedge aclk) begin
        if (watch_we) begin
            watch_mem[watch_addr] <= watch_wd;
        end
        if (watch_re) begin
            watch_q_reg <= watch_mem[watch_addr];
        end
    end

    // learned table memories
    always_ff @(posedge aclk) begin
        if (seq_id_we) begin
            seq_id_mem[seq_addr] <= id_reg;
        end
        if (seq_seen_we) begin
            seq_seen_mem[seq_addr] <= seq_seen_wd;
        end
        if (seq_re) begin
            seq_id_q_reg   <= seq_id_mem[seq_addr];
            seq_seen_q_reg <= seq_seen_mem[seq_addr];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_size_reg <= FILTER_SIZE_RST;
            period_us_reg   <= PERIOD_US_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FILTER_SIZE: filter_size_reg <= cfg_wdata[5:0];
                CFG_PERIOD_US:   period_us_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            lc_reg           <= '0;
            ptr_reg          <= '0;
            origin_reg       <= '0;
            ovalid_reg       <= 1'b0;
            hit_total_reg    <= '0;
            miss_total_reg   <= '0;
            check_active_reg <= 1'b0;
            active_reg       <= '0;
            m_tvalid         <= 1'b0;
        end else begin
            if (m_tvalid && m_tready && state_reg != ST_DONE) begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (&clr_cnt_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_xfer) begin
                        op_reg     <= s_opcode;
                        id_reg     <= s_can_id;
                        tsec_reg   <= s_tdata[46:15];
                        tusec_reg  <= s_tdata[66:47];
                        idx_reg    <= s_tdata[73:67];
                        status_reg <= 1'b0;
                        hit_reg    <= 1'b0;
                        eid_reg    <= '0;
                        ecnt_reg   <= '0;
                        state_reg  <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    i_reg     <= '0;
                    si_reg    <= '0;
                    j_reg     <= '0;
                    case (op_reg)
                        OP_SET_WATCH: begin
                            state_reg <= ST_DONE;
                        end
                        OP_LEARN: begin
                            if (watch_q_reg) begin
                                state_reg <= ST_LRN_ADDR;
                            end else begin
                                state_reg <= ST_DONE;
                            end
                        end
                        OP_BEGIN: begin
                            if (bad_start) begin
                                check_active_reg <= 1'b0;
                                status_reg       <= 1'b1;
                                state_reg        <= ST_DONE;
                            end else begin
                                active_reg <= SCW'(filter_size_reg);
                                state_reg  <= ST_LD_ADDR;
                            end
                        end
                        OP_CHECK: begin
                            if (!check_active_reg) begin
                                status_reg <= 1'b1;
                                state_reg  <= ST_DONE;
                            end else begin
                                prod_reg  <= TIME_W'(tsec_reg) * USEC_PER_SEC;
                                state_reg <= ST_TM_ADD;
                            end
                        end
                        OP_READ_ENTRY: begin
                            if (idx_ok) begin
                                state_reg <= ST_RD_WAIT;
                            end else begin
                                status_reg <= 1'b1;
                                state_reg  <= ST_DONE;
                            end
                        end
                        default: begin
                            status_reg <= 1'b1;
                            state_reg  <= ST_DONE;
                        end
                    endcase
                end
                // search the learned table, append when new
                ST_LRN_ADDR: begin
                    if (i_reg < lc_reg) begin
                        state_reg <= ST_LRN_CMP;
                    end else begin
                        if (32'(lc_reg) < 32'(SEQ_ENTRIES)) begin
                            lc_reg <= lc_reg + 1'b1;
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_LRN_CMP: begin
                    if (seq_id_q_reg == id_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_LRN_ADDR;
                    end
                end
                // load slots from the head of the learned table
                ST_LD_ADDR: begin
                    if (32'(i_reg) < 32'(filter_size_reg)) begin
                        state_reg <= ST_LD_WR;
                    end else begin
                        ptr_reg          <= SQIW'(filter_size_reg - 6'd1);
                        origin_reg       <= '0;
                        ovalid_reg       <= 1'b0;
                        hit_total_reg    <= '0;
                        miss_total_reg   <= '0;
                        check_active_reg <= 1'b1;
                        state_reg        <= ST_DONE;
                    end
                end
                ST_LD_WR: begin
                    slot_ident_reg[i_reg[SIW-1:0]]  <= seq_id_q_reg;
                    slot_logged_reg[i_reg[SIW-1:0]] <= 1'b0;
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= ST_LD_ADDR;
                end
                // timestamp in microseconds
                ST_TM_ADD: begin
                    now_reg   <= prod_reg + TIME_W'(tusec_reg);
                    state_reg <= ST_TM_CMP;
                end
                ST_TM_CMP: begin
                    ovalid_reg <= 1'b1;
                    if (delta >= TIME_W'(period_us_reg)) begin
                        origin_reg <= now_reg;
                        state_reg  <= ST_RT_SLOT;
                    end else begin
                        if (!ovalid_reg) begin
                            origin_reg <= now_reg;
                        end
                        state_reg <= ST_LK_SCAN;
                    end
                end
                // rotation: replace each logged slot by the next learned id held in no slot, if any
                ST_RT_SLOT: begin
                    j_reg <= '0;
                    if (si_reg == active_reg) begin
                        state_reg <= ST_LK_SCAN;
                    end else if (!slot_logged_reg[si_reg[SIW-1:0]]) begin
                        si_reg <= si_reg + 1'b1;
                    end else begin
                        start_reg <= ptr_reg;
                        state_reg <= ST_RT_STEP;
                    end
                end
                ST_RT_STEP: begin
                    ptr_reg   <= ptr_next;
                    j_reg     <= '0;
                    state_reg <= ST_RT_SCAN;
                end
                ST_RT_SCAN: begin
                    if (j_reg == active_reg) begin
                        slot_ident_reg[si_reg[SIW-1:0]]  <= seq_id_q_reg;
                        slot_logged_reg[si_reg[SIW-1:0]] <= 1'b0;
                        si_reg    <= si_reg + 1'b1;
                        state_reg <= ST_RT_SLOT;
                    end else if (slot_j == seq_id_q_reg) begin
                        if (ptr_reg == start_reg) begin
                            si_reg    <= si_reg + 1'b1;
                            state_reg <= ST_RT_SLOT;
                        end else begin
                            state_reg <= ST_RT_STEP;
                        end
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                // lookup of the watched id
                ST_LK_SCAN: begin
                    if (!watch_q_reg) begin
                        state_reg <= ST_DONE;
                    end else if (j_reg == active_reg) begin
                        if (miss_total_reg != SAT32) begin
                            miss_total_reg <= miss_total_reg + 32'd1;
                        end
                        state_reg <= ST_DONE;
                    end else if (slot_j == id_reg) begin
                        slot_logged_reg[j_reg[SIW-1:0]] <= 1'b1;
                        hit_reg <= 1'b1;
                        if (hit_total_reg != SAT32) begin
                            hit_total_reg <= hit_total_reg + 32'd1;
                        end
                        state_reg <= ST_DONE;
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_RD_WAIT: begin
                    eid_reg   <= seq_id_q_reg;
                    ecnt_reg  <= seq_seen_q_reg;
                    state_reg <= ST_DONE;
                end
                // hand the result to the output register
                ST_DONE: begin
                    if (!m_tvalid || m_tready) begin
                        m_tvalid  <= 1'b1;
                        m_tdata   <= {3'b000, 8'(lc_reg), ecnt_reg, eid_reg, miss_total_reg,
                                      hit_total_reg, hit_reg, status_reg};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // learned count never passes the table depth
    a_lc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(lc_reg) <= 32'(SEQ_ENTRIES))
        else $error("learned count beyond table depth");

    // an active check has a legal slot count backed by learned entries
    a_active_slots: assert property (@(posedge aclk) disable iff (!aresetn)
        check_active_reg |-> (active_reg != '0) && (32'(active_reg) <= 32'(FILTER_SLOTS))
                             && (32'(active_reg) <= 32'(lc_reg)))
        else $error("active slot count out of range");

    // rotation pointer stays inside the learned table
    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        check_active_reg |-> (32'(ptr_reg) < 32'(lc_reg)))
        else $error("rotation pointer beyond learned entries");

    // one item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_tready)
        else $error("item taken while busy");

endmodule
`default_nettype wire
